[sv/sse_pkg.sv]
// Package: shared types and constants of the sample statistics engine.
`default_nettype none
package sse_pkg;

  localparam int unsigned MaxCount   = 1024;
  localparam int unsigned SampleW    = 16;
  localparam int unsigned CountW     = 11;
  localparam int unsigned SumW       = 26;
  localparam int unsigned SqW        = 41;
  localparam int unsigned NumW       = 52;
  localparam int unsigned DivCntW    = 6;
  localparam int unsigned RootW      = 16;
  localparam int unsigned RadW       = 32;
  localparam int unsigned SqSplit    = 21;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SHORT    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_NUM,
    OP_DIV_MEAN,
    OP_DIV_SS,
    OP_DIV_VS,
    OP_DIV_VP,
    OP_SQRT_S,
    OP_SQRT_P,
    OP_PUBLISH
  } sse_op_e;

  typedef struct packed {
    logic    acc;
    sse_op_e op;
  } sse_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic n_lt2;
    logic n_zero;
  } sse_stat_t;

endpackage
`default_nettype wire

[sv/sse_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module sse_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [sse_pkg::NumW-1:0]    dividend_i,
  input  wire logic [sse_pkg::CountW-1:0]  divisor_i,
  output logic                             done_o,
  output logic [sse_pkg::NumW-1:0]         quotient_o
);

  logic [sse_pkg::NumW-1:0]    quo_q, quo_d;
  logic [sse_pkg::CountW-1:0]  rem_q, rem_d;
  logic [sse_pkg::CountW-1:0]  dsr_q, dsr_d;
  logic [sse_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic                        done_q, done_d;
  logic [sse_pkg::CountW:0]    rem_sh;
  logic                        ge;

  assign rem_sh = {rem_q, quo_q[sse_pkg::NumW-1]};
  assign ge     = rem_sh >= {1'b0, dsr_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      dsr_d = divisor_i;
      cnt_d = sse_pkg::DivCntW'(sse_pkg::NumW);
    end else if (cnt_q != '0) begin
      if (ge) begin
        rem_d = sse_pkg::CountW'(rem_sh - {1'b0, dsr_q});
      end else begin
        rem_d = rem_sh[sse_pkg::CountW-1:0];
      end
      quo_d  = {quo_q[sse_pkg::NumW-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == sse_pkg::DivCntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

[sv/sse_sqrt.sv]
// Bitwise floor integer square root, one result bit per cycle.
`default_nettype none
module sse_sqrt (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [sse_pkg::RadW-1:0]   radicand_i,
  output logic                            done_o,
  output logic [sse_pkg::RootW-1:0]       root_o
);

  logic [sse_pkg::RadW-1:0]  rad_q, rad_d;
  logic [sse_pkg::RootW-1:0] res_q, res_d;
  logic [sse_pkg::RootW-1:0] bit_q, bit_d;
  logic                      done_q, done_d;
  logic [sse_pkg::RootW-1:0] trial;
  logic [sse_pkg::RadW-1:0]  trial_sq;

  assign trial    = res_q | bit_q;
  assign trial_sq = trial * trial;

  always_comb begin
    rad_d  = rad_q;
    res_d  = res_q;
    bit_d  = bit_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d = radicand_i;
      res_d = '0;
      bit_d = {1'b1, {(sse_pkg::RootW-1){1'b0}}};
    end else if (bit_q != '0) begin
      if (trial_sq <= rad_q) begin
        res_d = trial;
      end
      bit_d  = bit_q >> 1;
      done_d = bit_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q  <= '0;
      done_q <= 1'b0;
    end else begin
      bit_q  <= bit_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q <= rad_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign root_o = res_q;

endmodule
`default_nettype wire

[sv/sse_dp.sv]
// Datapath: accumulators, batch snapshot, products, shared divider and root unit.
`default_nettype none
module sse_dp (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire sse_pkg::sse_cmd_t                  cmd_i,
  output sse_pkg::sse_stat_t                      stat_o,
  input  wire logic signed [sse_pkg::SampleW-1:0] sample_i,
  input  wire logic                               last_sample_i,
  output logic [10:0]                             sample_count_o,
  output logic signed [25:0]                      total_sum_o,
  output logic [40:0]                             raw_square_sum_o,
  output logic signed [15:0]                      mean_value_o,
  output logic [40:0]                             centered_square_sum_o,
  output logic [31:0]                             variance_sample_o,
  output logic [30:0]                             variance_population_o,
  output logic [15:0]                             deviation_sample_o,
  output logic [15:0]                             deviation_population_o,
  output logic [1:0]                              status_o
);

  logic signed [sse_pkg::SumW-1:0] acc_sum_q;
  logic [sse_pkg::SqW-1:0]         acc_sq_q;
  logic [sse_pkg::CountW-1:0]      acc_cnt_q;
  logic                            acc_ovf_q;

  logic signed [sse_pkg::SumW-1:0] sum_nx;
  logic [sse_pkg::SqW-1:0]         sq_nx;
  logic [sse_pkg::CountW-1:0]      cnt_nx;
  logic                            ovf_nx;
  logic signed [31:0]              smp_sq;

  logic [sse_pkg::CountW-1:0]      n_q;
  logic signed [sse_pkg::SumW-1:0] sum_q;
  logic [sse_pkg::SqW-1:0]         sq_q;
  logic                            ovf_q;
  logic                            neg_q;
  logic [sse_pkg::SumW-1:0]        mag_q;

  logic [31:0]                     plo_q;
  logic [30:0]                     phi_q;
  logic [sse_pkg::NumW-1:0]        sqm_q;
  logic [sse_pkg::NumW-1:0]        num_q;
  logic [sse_pkg::NumW:0]          num_sum;

  logic signed [15:0]              mean_q;
  logic [40:0]                     ss_q;
  logic [31:0]                     vs_q;
  logic [30:0]                     vp_q;
  logic [15:0]                     sds_q;
  logic [15:0]                     sdp_q;
  sse_pkg::sse_op_e                dst_q;
  logic                            rdst_q;

  logic                            div_start;
  logic [sse_pkg::NumW-1:0]        div_dvd;
  logic [sse_pkg::CountW-1:0]      div_dsr;
  logic                            div_done;
  logic [sse_pkg::NumW-1:0]        div_quo;
  logic                            sqrt_start;
  logic [sse_pkg::RadW-1:0]        sqrt_rad;
  logic                            sqrt_done;
  logic [sse_pkg::RootW-1:0]       sqrt_root;
  logic [15:0]                     mean_mag;

  assign smp_sq = sample_i * sample_i;

  always_comb begin
    sum_nx = acc_sum_q;
    sq_nx  = acc_sq_q;
    cnt_nx = acc_cnt_q;
    ovf_nx = acc_ovf_q;
    if (acc_cnt_q < sse_pkg::CountW'(sse_pkg::MaxCount)) begin
      sum_nx = acc_sum_q + sse_pkg::SumW'(sample_i);
      sq_nx  = acc_sq_q + sse_pkg::SqW'(smp_sq[30:0]);
      cnt_nx = acc_cnt_q + 1'b1;
    end else begin
      ovf_nx = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_sum_q <= '0;
      acc_sq_q  <= '0;
      acc_cnt_q <= '0;
      acc_ovf_q <= 1'b0;
    end else if (cmd_i.acc) begin
      if (last_sample_i) begin
        acc_sum_q <= '0;
        acc_sq_q  <= '0;
        acc_cnt_q <= '0;
        acc_ovf_q <= 1'b0;
      end else begin
        acc_sum_q <= sum_nx;
        acc_sq_q  <= sq_nx;
        acc_cnt_q <= cnt_nx;
        acc_ovf_q <= ovf_nx;
      end
    end
  end

  assign num_sum = {1'b0, sse_pkg::NumW'(plo_q)}
                 + {1'b0, sse_pkg::NumW'({phi_q, {sse_pkg::SqSplit{1'b0}}})}
                 - {1'b0, sqm_q};

  always_comb begin
    div_start = 1'b0;
    div_dvd   = num_q;
    div_dsr   = n_q;
    case (cmd_i.op)
      sse_pkg::OP_DIV_MEAN: begin
        div_start = 1'b1;
        div_dvd   = sse_pkg::NumW'(mag_q);
      end
      sse_pkg::OP_DIV_SS: begin
        div_start = 1'b1;
      end
      sse_pkg::OP_DIV_VS: begin
        div_start = 1'b1;
        div_dvd   = sse_pkg::NumW'(ss_q);
        div_dsr   = n_q - 1'b1;
      end
      sse_pkg::OP_DIV_VP: begin
        div_start = 1'b1;
        div_dvd   = sse_pkg::NumW'(ss_q);
      end
      default: begin
      end
    endcase
  end

  assign sqrt_start = (cmd_i.op == sse_pkg::OP_SQRT_S) || (cmd_i.op == sse_pkg::OP_SQRT_P);
  assign sqrt_rad   = (cmd_i.op == sse_pkg::OP_SQRT_S) ? vs_q : {1'b0, vp_q};
  assign mean_mag   = div_quo[15:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc && last_sample_i) begin
      n_q    <= cnt_nx;
      sum_q  <= sum_nx;
      sq_q   <= sq_nx;
      ovf_q  <= ovf_nx;
      neg_q  <= sum_nx[sse_pkg::SumW-1];
      mag_q  <= sum_nx[sse_pkg::SumW-1] ? sse_pkg::SumW'(-sum_nx) : sse_pkg::SumW'(sum_nx);
      mean_q <= '0;
      ss_q   <= '0;
      vs_q   <= '0;
      vp_q   <= '0;
      sds_q  <= '0;
      sdp_q  <= '0;
    end
    case (cmd_i.op)
      sse_pkg::OP_MUL_LO: begin
        plo_q <= n_q * sq_q[sse_pkg::SqSplit-1:0];
        sqm_q <= mag_q * mag_q;
      end
      sse_pkg::OP_MUL_HI: phi_q <= n_q * sq_q[sse_pkg::SqW-1:sse_pkg::SqSplit];
      sse_pkg::OP_NUM:    num_q <= num_sum[sse_pkg::NumW-1:0];
      default: begin
      end
    endcase
    if (div_start) begin
      dst_q <= cmd_i.op;
    end
    if (sqrt_start) begin
      rdst_q <= (cmd_i.op == sse_pkg::OP_SQRT_S);
    end
    if (div_done) begin
      case (dst_q)
        sse_pkg::OP_DIV_MEAN: mean_q <= neg_q ? -mean_mag : mean_mag;
        sse_pkg::OP_DIV_SS:   ss_q   <= div_quo[40:0];
        sse_pkg::OP_DIV_VS:   vs_q   <= div_quo[31:0];
        sse_pkg::OP_DIV_VP:   vp_q   <= div_quo[30:0];
        default: begin
        end
      endcase
    end
    if (sqrt_done) begin
      if (rdst_q) begin
        sds_q <= sqrt_root;
      end else begin
        sdp_q <= sqrt_root;
      end
    end
    if (cmd_i.op == sse_pkg::OP_PUBLISH) begin
      sample_count_o         <= n_q;
      total_sum_o            <= sum_q;
      raw_square_sum_o       <= sq_q;
      mean_value_o           <= mean_q;
      centered_square_sum_o  <= ss_q;
      variance_sample_o      <= vs_q;
      variance_population_o  <= vp_q;
      deviation_sample_o     <= sds_q;
      deviation_population_o <= sdp_q;
      status_o               <= ovf_q ? sse_pkg::ST_OVERFLOW
                              : (n_q < sse_pkg::CountW'(2)) ? sse_pkg::ST_SHORT
                              : sse_pkg::ST_OK;
    end
  end

  sse_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  sse_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (sqrt_rad),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  assign stat_o.div_done  = div_done;
  assign stat_o.sqrt_done = sqrt_done;
  assign stat_o.n_lt2     = n_q < sse_pkg::CountW'(2);
  assign stat_o.n_zero    = n_q == '0;

endmodule
`default_nettype wire

[sv/sse_ctrl.sv]
// Controller: batch sequencing state machine and output valid.
`default_nettype none
module sse_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               last_sample_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  input  wire sse_pkg::sse_stat_t stat_i,
  output sse_pkg::sse_cmd_t       cmd_o
);

  localparam logic [4:0] S_ACC    = 5'd0;
  localparam logic [4:0] S_MUL_LO = 5'd1;
  localparam logic [4:0] S_MUL_HI = 5'd2;
  localparam logic [4:0] S_NUM    = 5'd3;
  localparam logic [4:0] S_MEAN   = 5'd4;
  localparam logic [4:0] S_MEAN_W = 5'd5;
  localparam logic [4:0] S_SS     = 5'd6;
  localparam logic [4:0] S_SS_W   = 5'd7;
  localparam logic [4:0] S_VS     = 5'd8;
  localparam logic [4:0] S_VS_W   = 5'd9;
  localparam logic [4:0] S_VP     = 5'd10;
  localparam logic [4:0] S_VP_W   = 5'd11;
  localparam logic [4:0] S_SDS    = 5'd12;
  localparam logic [4:0] S_SDS_W  = 5'd13;
  localparam logic [4:0] S_SDP    = 5'd14;
  localparam logic [4:0] S_SDP_W  = 5'd15;
  localparam logic [4:0] S_DONE   = 5'd16;

  logic [4:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q & out_stall_i;
    cmd_o.acc   = 1'b0;
    cmd_o.op    = sse_pkg::OP_NONE;
    unique case (state_q)
      S_ACC: begin
        cmd_o.acc = in_valid_i;
        if (in_valid_i && last_sample_i) begin
          state_d = S_MUL_LO;
        end
      end
      S_MUL_LO: begin
        cmd_o.op = sse_pkg::OP_MUL_LO;
        state_d  = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd_o.op = sse_pkg::OP_MUL_HI;
        state_d  = S_NUM;
      end
      S_NUM: begin
        cmd_o.op = sse_pkg::OP_NUM;
        state_d  = stat_i.n_zero ? S_DONE : S_MEAN;
      end
      S_MEAN: begin
        cmd_o.op = sse_pkg::OP_DIV_MEAN;
        state_d  = S_MEAN_W;
      end
      S_MEAN_W: if (stat_i.div_done) begin
        state_d = stat_i.n_lt2 ? S_DONE : S_SS;
      end
      S_SS: begin
        cmd_o.op = sse_pkg::OP_DIV_SS;
        state_d  = S_SS_W;
      end
      S_SS_W: if (stat_i.div_done) begin
        state_d = S_VS;
      end
      S_VS: begin
        cmd_o.op = sse_pkg::OP_DIV_VS;
        state_d  = S_VS_W;
      end
      S_VS_W: if (stat_i.div_done) begin
        state_d = S_VP;
      end
      S_VP: begin
        cmd_o.op = sse_pkg::OP_DIV_VP;
        state_d  = S_VP_W;
      end
      S_VP_W: if (stat_i.div_done) begin
        state_d = S_SDS;
      end
      S_SDS: begin
        cmd_o.op = sse_pkg::OP_SQRT_S;
        state_d  = S_SDS_W;
      end
      S_SDS_W: if (stat_i.sqrt_done) begin
        state_d = S_SDP;
      end
      S_SDP: begin
        cmd_o.op = sse_pkg::OP_SQRT_P;
        state_d  = S_SDP_W;
      end
      S_SDP_W: if (stat_i.sqrt_done) begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.op    = sse_pkg::OP_PUBLISH;
          out_valid_d = 1'b1;
          state_d     = S_ACC;
        end
      end
      default: state_d = S_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_ACC;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != S_ACC;
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

[sv/sample_statistics_engine_unit.sv]
// Top level: sample statistics engine, controller plus datapath.
// Samples transfer one per cycle while a batch accumulates; after the last one input
// stalls through three product steps, four divider passes, two roots and one publish
// step (a batch of one sample stops after the mean division, an empty batch before it).
// Publish waits while the previous result is still stalled in the output register.
// Reset clears accumulators, control state and output valid.
`default_nettype none
module sample_statistics_engine_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] sample_i,
  input  wire logic               last_sample_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [10:0]             sample_count_o,
  output logic signed [25:0]      total_sum_o,
  output logic [40:0]             raw_square_sum_o,
  output logic signed [15:0]      mean_value_o,
  output logic [40:0]             centered_square_sum_o,
  output logic [31:0]             variance_sample_o,
  output logic [30:0]             variance_population_o,
  output logic [15:0]             deviation_sample_o,
  output logic [15:0]             deviation_population_o,
  output logic [1:0]              status_o
);

  sse_pkg::sse_cmd_t  cmd;
  sse_pkg::sse_stat_t stat;

  sse_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .last_sample_i (last_sample_i),
    .in_stall_o    (in_stall_o),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  sse_dp u_dp (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cmd_i                  (cmd),
    .stat_o                 (stat),
    .sample_i               (sample_i),
    .last_sample_i          (last_sample_i),
    .sample_count_o         (sample_count_o),
    .total_sum_o            (total_sum_o),
    .raw_square_sum_o       (raw_square_sum_o),
    .mean_value_o           (mean_value_o),
    .centered_square_sum_o  (centered_square_sum_o),
    .variance_sample_o      (variance_sample_o),
    .variance_population_o  (variance_population_o),
    .deviation_sample_o     (deviation_sample_o),
    .deviation_population_o (deviation_population_o),
    .status_o               (status_o)
  );

endmodule
`default_nettype wire

[dv/testbench.sv]
// Testbench for the sample statistics engine: directed and random batches vs a predictor.
`default_nettype none
module testbench;

  typedef struct {
    logic [10:0] count;
    logic [25:0] sum;
    logic [40:0] sqsum;
    logic [15:0] mean;
    logic [40:0] css;
    logic [31:0] vs;
    logic [30:0] vp;
    logic [15:0] ds;
    logic [15:0] dp;
    logic [1:0]  status;
  } stats_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [15:0] sample_i;
  logic               last_sample_i;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [10:0]        sample_count_o;
  logic signed [25:0] total_sum_o;
  logic [40:0]        raw_square_sum_o;
  logic signed [15:0] mean_value_o;
  logic [40:0]        centered_square_sum_o;
  logic [31:0]        variance_sample_o;
  logic [30:0]        variance_population_o;
  logic [15:0]        deviation_sample_o;
  logic [15:0]        deviation_population_o;
  logic [1:0]         status_o;

  sample_statistics_engine_unit u_dut (.*);

  stats_t      expected_stats[$];
  int          mismatches = 0;
  bit          calm;
  longint      acc_sum;
  longint unsigned acc_sq;
  int unsigned acc_n;
  bit          acc_ovf;
  int          idle_cnt = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic accumulate_sample(logic signed [15:0] s, logic lst);
    stats_t e;
    longint unsigned smag;
    longint unsigned ss;
    longint unsigned vs;
    longint unsigned vp;
    longint signed   mn;
    if (acc_n < sse_pkg::MaxCount) begin
      acc_sum += s;
      acc_sq  += longint'(s) * longint'(s);
      acc_n++;
    end else begin
      acc_ovf = 1'b1;
    end
    if (!lst) return;
    smag = (acc_sum < 0) ? -acc_sum : acc_sum;
    mn = 0;
    if (acc_n != 0) mn = acc_sum / longint'(acc_n);
    ss = 0; vs = 0; vp = 0;
    if (acc_n >= 2) begin
      ss = (acc_n * acc_sq - smag * smag) / acc_n;
      vs = ss / (acc_n - 1);
      vp = ss / acc_n;
    end
    e.count  = 11'(acc_n);
    e.sum    = 26'(acc_sum);
    e.sqsum  = 41'(acc_sq);
    e.mean   = 16'(mn);
    e.css    = 41'(ss);
    e.vs     = 32'(vs);
    e.vp     = 31'(vp);
    e.ds     = 16'(int_sqrt(vs));
    e.dp     = 16'(int_sqrt(vp));
    e.status = acc_ovf ? sse_pkg::ST_OVERFLOW
             : (acc_n < 2 ? sse_pkg::ST_SHORT : sse_pkg::ST_OK);
    expected_stats.push_back(e);
    acc_sum = 0; acc_sq = 0; acc_n = 0; acc_ovf = 1'b0;
  endtask

  task automatic send_sample(logic signed [15:0] s, logic lst);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sample_i      <= s;
    last_sample_i <= lst;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    accumulate_sample(s, lst);
  endtask

  task automatic finish_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 4))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($urandom_range(0, 511) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_sample(16'sh0100, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'shffff, 1'b0);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'sh0001, 1'b1);
    send_sample(16'sh5555, 1'b0);
    send_sample(16'shaaaa, 1'b1);
    send_sample(16'sh8000, 1'b1);
  endtask

  // full batch at extremes, one extra ignored sample, then an ignored sample ends the batch
  task automatic test_overflow();
    for (int i = 0; i < sse_pkg::MaxCount; i++)
      send_sample((i % 2) ? 16'sh7fff : 16'sh8000, 1'b0);
    send_sample(16'sh1234, 1'b0);
    send_sample(16'sh8000, 1'b1);
  endtask

  task automatic test_drain_pause();
    finish_input();
    while (expected_stats.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_random(int total);
    int len;
    int sent;
    sent = 0;
    while (sent < total) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(2, 30);
      if (len == 0) len = 1;
      for (int i = 0; i < len; i++) send_sample(rand_sample(), i == len - 1);
      sent += len;
    end
  endtask

  always @(posedge clk_i) begin
    if (!calm && idle_cnt == 0 && $urandom_range(0, 6) == 0) begin
      idle_cnt = $urandom_range(1, 7);
    end
    out_stall_i <= (!calm && idle_cnt > 0);
    if (idle_cnt > 0) idle_cnt--;
  end

  always @(posedge clk_i) begin
    stats_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer");
      end else begin
        e = expected_stats.pop_front();
        if (sample_count_o !== e.count || total_sum_o !== e.sum ||
            raw_square_sum_o !== e.sqsum || mean_value_o !== e.mean ||
            centered_square_sum_o !== e.css || variance_sample_o !== e.vs ||
            variance_population_o !== e.vp || deviation_sample_o !== e.ds ||
            deviation_population_o !== e.dp || status_o !== e.status) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp n=%0d s=%0d q=%0d m=%0d c=%0d vs=%0d vp=%0d ds=%0d dp=%0d st=%0d",
              e.count, $signed(e.sum), e.sqsum, $signed(e.mean), e.css, e.vs, e.vp,
              e.ds, e.dp, e.status);
            $display("         act n=%0d s=%0d q=%0d m=%0d c=%0d vs=%0d vp=%0d ds=%0d dp=%0d st=%0d",
              sample_count_o, total_sum_o, raw_square_sum_o, mean_value_o,
              centered_square_sum_o, variance_sample_o, variance_population_o,
              deviation_sample_o, deviation_population_o, status_o);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
      if (quiet >= 20000) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int spin;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    sample_i = '0;
    last_sample_i = 1'b0;
    calm = 1'b0;
    acc_sum = 0; acc_sq = 0; acc_n = 0; acc_ovf = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_drain_pause();
    test_overflow();
    test_random(450);
    calm = 1'b1;
    test_random(150);
    finish_input();
    spin = 0;
    while (expected_stats.size() != 0 && spin < 100000) begin
      @(posedge clk_i);
      spin++;
    end
    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && expected_stats.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire

[filelist.f]
sv/sse_pkg.sv
sv/sse_div.sv
sv/sse_sqrt.sv
sv/sse_dp.sv
sv/sse_ctrl.sv
sv/sample_statistics_engine_unit.sv
dv/testbench.sv
